[rtl/core/mfr_pkg.sv]
// Package for the message frame receiver: parser phase codes and the result record.
// It has no dependencies, and every module of the block imports it.
`default_nettype none

package mfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned PosnW = 16;

  typedef enum logic [2:0] {
    PH_FILE  = 3'd0,
    PH_COUNT = 3'd1,
    PH_OP    = 3'd2,
    PH_POSLO = 3'd3,
    PH_POSHI = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] file_id;
    logic [ByteW-1:0] op_code;
    logic [PosnW-1:0] position;
    logic [LenW-1:0]  payload_len;
    logic             has_data;
    logic [ByteW-1:0] data_byte;
    logic             frame_end;
  } mfr_result_t;

endpackage

`default_nettype wire

[rtl/core/mfr_in_stage.sv]
// Input register of the message frame receiver: holds one link byte until the parser takes it.
// Depends on mfr_pkg.
`default_nettype none

module mfr_in_stage (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_valid_i,
  output logic                          s_ready_o,
  input  wire logic [mfr_pkg::ByteW-1:0] s_byte_i,
  input  wire logic                     advance_i,
  output logic                          byte_valid_o,
  output logic [mfr_pkg::ByteW-1:0]     byte_o
);
  import mfr_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             take;

  assign s_ready_o = !valid_q || advance_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= s_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

`default_nettype wire

[rtl/core/mfr_parser.sv]
// Frame parser: phase state machine, captured header and the result built from each byte.
// Depends on mfr_pkg.
`default_nettype none

module mfr_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [mfr_pkg::ByteW-1:0] byte_i,
  output logic                           res_valid_o,
  output mfr_pkg::mfr_result_t           res_o
);
  import mfr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  remaining_q, remaining_d;
  logic [ByteW-1:0] file_q, file_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] op_q, op_d;
  logic [PosnW-1:0] posn_q, posn_d;
  logic             last;

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    file_d      = file_q;
    len_d       = len_q;
    op_d        = op_q;
    posn_d      = posn_q;
    res_valid_o = 1'b0;
    last        = (remaining_q <= LenW'(1));
    unique case (phase_q)
      PH_FILE: begin
        file_d  = byte_i;
        phase_d = PH_COUNT;
      end
      PH_COUNT: begin
        if (byte_i[ByteW-1] || (byte_i == '0)) begin
          len_d = '0;
        end else begin
          len_d = byte_i[LenW-1:0];
        end
        remaining_d = len_d;
        phase_d     = PH_OP;
      end
      PH_OP: begin
        op_d    = byte_i;
        phase_d = PH_POSLO;
      end
      PH_POSLO: begin
        posn_d  = {{(PosnW-ByteW){1'b0}}, byte_i};
        phase_d = PH_POSHI;
      end
      PH_POSHI: begin
        posn_d = {byte_i, posn_q[ByteW-1:0]};
        if (remaining_q == '0) begin
          res_valid_o = 1'b1;
          phase_d     = PH_FILE;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid_o = 1'b1;
        if (last) begin
          remaining_d = '0;
          phase_d     = PH_FILE;
        end else begin
          remaining_d = remaining_q - LenW'(1);
        end
      end
      default: begin
        phase_d = PH_FILE;
      end
    endcase
  end

  always_comb begin
    res_o.file_id     = file_q;
    res_o.op_code     = op_q;
    res_o.position    = posn_d;
    res_o.payload_len = len_q;
    res_o.has_data    = (phase_q == PH_DATA);
    res_o.data_byte   = (phase_q == PH_DATA) ? byte_i : '0;
    res_o.frame_end   = (phase_q == PH_DATA) ? last : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FILE;
      remaining_q <= '0;
      file_q      <= '0;
      len_q       <= '0;
      op_q        <= '0;
      posn_q      <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      file_q      <= file_d;
      len_q       <= len_d;
      op_q        <= op_d;
      posn_q      <= posn_d;
    end
  end

`ifndef SYNTHESIS
  a_data_has_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (remaining_q != '0))
    else $error("payload phase entered with nothing remaining");

  a_remaining_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (remaining_q <= len_q))
    else $error("remaining count exceeds frame length");

  a_header_only_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.has_data) |->
      (res_o.frame_end && (res_o.data_byte == '0) && (res_o.payload_len == '0)))
    else $error("header-only result is malformed");

  a_step_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_FILE)) |=> (phase_q == PH_COUNT))
    else $error("file byte did not advance to the count phase");
`endif

endmodule

`default_nettype wire

[rtl/core/mfr_out_stage.sv]
// Result register of the message frame receiver, presenting one result to the output channel.
// Depends on mfr_pkg.
`default_nettype none

module mfr_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire mfr_pkg::mfr_result_t res_i,
  output logic                      advance_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output mfr_pkg::mfr_result_t      m_res_o
);
  import mfr_pkg::*;

  logic        valid_q, valid_d;
  mfr_result_t res_q;

  assign advance_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

`default_nettype wire

[rtl/core/message_frame_receiver_core.sv]
// Top level of the message frame receiver: input register, frame parser and result register.
// Depends on mfr_pkg, mfr_in_stage, mfr_parser and mfr_out_stage.
//
// The slave channel takes one link byte per transfer. A frame is a file byte, a signed
// count byte, an op byte, the position low and high bytes, then count payload bytes.
// Header bytes give no result. Each payload byte gives one result on the master channel
// carrying the captured header, with tuser high and tlast on the last byte of the frame.
// A frame whose count is zero or negative gives one header-only result when its position
// high byte arrives, with tuser low, a zero data byte and tlast high.
// A byte is held in the input register and is parsed into the result register once that
// register can take it; the result is then presented on the master channel.
// One byte is taken every cycle while the master side keeps up; the only limit is the
// single result register, which the parser refills in the cycle it is emptied.
// When the master side stalls, the result and one byte in the input register are held and
// tready falls. Reset clears both registers, returns the parser to wait for a file byte
// and empties the captured header.
`default_nettype none

module message_frame_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // link_byte [7:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // file_id [7:0], op_code [15:8], position [31:16], payload_len [38:32],
  // data_byte [46:39], zero [47]
  output logic [47:0]      m_axis_tdata_o,
  output logic             m_axis_tuser_o,   // has_data
  output logic             m_axis_tlast_o    // frame_end
);
  import mfr_pkg::*;

  logic             advance;
  logic             byte_valid;
  logic [ByteW-1:0] byte_q;
  logic             step;
  logic             res_valid;
  mfr_result_t      res;
  mfr_result_t      m_res;

  mfr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_byte_i     (s_axis_tdata_i),
    .advance_i    (advance),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_q)
  );

  assign step = byte_valid && advance;

  mfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mfr_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step && res_valid),
    .res_i     (res),
    .advance_o (advance),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata_o = {1'b0, m_res.data_byte, m_res.payload_len, m_res.position,
                           m_res.op_code, m_res.file_id};
  assign m_axis_tuser_o = m_res.has_data;
  assign m_axis_tlast_o = m_res.frame_end;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for message_frame_receiver_core: it sends directed and random frames
// over the link stream and checks every result against its own frame parser.
// Depends on mfr_pkg and the block's RTL.
`default_nettype none

module tb_top;
  import mfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // link_byte [7:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // file_id [7:0], op_code [15:8], position [31:16], payload_len [38:32],
  // data_byte [46:39], zero [47]
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;   // has_data
  logic        m_axis_tlast_o;   // frame_end

  phase_e           parse_phase;
  logic [LenW-1:0]  bytes_left;
  logic [ByteW-1:0] hdr_file;
  logic [LenW-1:0]  hdr_len;
  logic [ByteW-1:0] hdr_op;
  logic [PosnW-1:0] hdr_posn;

  mfr_result_t pending_results[$];
  mfr_result_t oldest_result;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned link_bytes_sent;

  message_frame_receiver_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic void push_frame_result(input logic has, input logic [7:0] value,
                                            input logic last);
    mfr_result_t res;
    res.file_id     = hdr_file;
    res.op_code     = hdr_op;
    res.position    = hdr_posn;
    res.payload_len = hdr_len;
    res.has_data    = has;
    res.data_byte   = value;
    res.frame_end   = last;
    pending_results.push_back(res);
  endfunction

  function automatic void parse_link_byte(input logic [7:0] value);
    logic last;
    case (parse_phase)
      PH_FILE: begin
        hdr_file    = value;
        parse_phase = PH_COUNT;
      end
      PH_COUNT: begin
        // The count is signed, so any value with the top bit set means no payload.
        hdr_len     = (value == 8'd0 || value[7]) ? '0 : value[6:0];
        bytes_left  = hdr_len;
        parse_phase = PH_OP;
      end
      PH_OP: begin
        hdr_op      = value;
        parse_phase = PH_POSLO;
      end
      PH_POSLO: begin
        hdr_posn    = {8'h00, value};
        parse_phase = PH_POSHI;
      end
      PH_POSHI: begin
        hdr_posn[15:8] = value;
        if (bytes_left == '0) begin
          parse_phase = PH_FILE;
          push_frame_result(1'b0, 8'h00, 1'b1);
        end else begin
          parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        last       = (bytes_left <= 7'd1);
        bytes_left = last ? '0 : bytes_left - 7'd1;
        if (last) begin
          parse_phase = PH_FILE;
        end
        push_frame_result(1'b1, value, last);
      end
      default: begin
        parse_phase = PH_FILE;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] expected,
                                      input logic [15:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: tdata %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("file_id", 16'(oldest_result.file_id), 16'(m_axis_tdata_o[7:0]));
        check_field("op_code", 16'(oldest_result.op_code), 16'(m_axis_tdata_o[15:8]));
        check_field("position", oldest_result.position, m_axis_tdata_o[31:16]);
        check_field("payload_len", 16'(oldest_result.payload_len),
                    16'(m_axis_tdata_o[38:32]));
        check_field("data_byte", 16'(oldest_result.data_byte), 16'(m_axis_tdata_o[46:39]));
        check_field("has_data", 16'(oldest_result.has_data), 16'(m_axis_tuser_o));
        check_field("frame_end", 16'(oldest_result.frame_end), 16'(m_axis_tlast_o));
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_link_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_link_byte(value);
    link_bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] file, input logic [7:0] count,
                            input logic [7:0] op, input logic [15:0] posn);
    int n;
    n = (count == 8'd0 || count[7]) ? 0 : int'(count);
    send_link_byte(file);
    send_link_byte(count);
    send_link_byte(op);
    send_link_byte(posn[7:0]);
    send_link_byte(posn[15:8]);
    for (int i = 0; i < n; i++) begin
      send_link_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_field_extremes();
    send_frame(8'h00, 8'd1, 8'h00, 16'h0000);
    send_frame(8'hFF, 8'd2, 8'hFF, 16'hFFFF);
    send_frame(8'h00, 8'h7F, 8'hFF, 16'h0000);
  endtask

  task automatic test_nonpositive_count();
    send_frame(8'h5A, 8'h00, 8'hA5, 16'h1234);
    send_frame(8'hA5, 8'h80, 8'h5A, 16'hFEDC);
    send_frame(8'h3C, 8'hFF, 8'hC3, 16'h8001);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  count;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    stop_at        = link_bytes_sent + n_bytes;
    while (link_bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // Stray bytes knock the framing out of step with the frames that follow.
        repeat ($urandom_range(1, 4)) send_link_byte(8'($urandom_range(255)));
      end else begin
        if (pick < 15) begin
          count = $urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(128, 255));
        end else if (pick < 18) begin
          count = 8'($urandom_range(64, 127));
        end else begin
          count = 8'($urandom_range(1, 12));
        end
        send_frame(8'($urandom_range(255)), count, 8'($urandom_range(255)),
                   16'($urandom_range(65535)));
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    m_axis_tready_i = 1'b0;
    parse_phase     = PH_FILE;
    bytes_left      = '0;
    hdr_file        = '0;
    hdr_len         = '0;
    hdr_op          = '0;
    hdr_posn        = '0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 0;
    sink_stall_pct  = 0;
    link_bytes_sent = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_field_extremes();
    test_nonpositive_count();
    test_random_traffic(0, 0, 475);
    test_random_traffic(47, 0, 475);
    test_random_traffic(0, 47, 475);
    test_random_traffic(26, 26, 475);

    s_axis_tvalid_i <= 1'b0;
    sink_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
